/* rtl/sird_pkg.sv */
`default_nettype none

package sird_pkg;

  localparam int unsigned MAX_SYMBOLS   = 16;
  localparam int unsigned MAX_DIGITS    = 32;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned SYM_W         = 8;
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned RADIX_W       = 5;
  localparam int unsigned CNT_W         = 6;
  localparam int unsigned BITS_PER_STEP = 8;
  localparam int unsigned DIV_STEPS     = VALUE_W / BITS_PER_STEP;
  localparam int unsigned STEP_W        = $clog2(DIV_STEPS);
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [SYM_W-1:0] CH_MINUS = 8'd45;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [SYM_W-1:0] CH_LOW   = 8'd32;
  localparam logic [SYM_W-1:0] CH_HIGH  = 8'd127;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 64;

  localparam logic [1:0] REG_SYMBOL_COUNT = 2'd0;
  localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

  typedef struct packed {
    logic                                ok;
    logic [RADIX_W-1:0]                  radix;
    logic [MAX_SYMBOLS-1:0][SYM_W-1:0]   sym;
  } cfg_t;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } job_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_SIGN,
    B_RD,
    B_EMIT
  } back_state_e;

endpackage

`default_nettype wire

/* rtl/sird_ram.sv */
`default_nettype none

module sird_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/sird_fifo.sv */
`default_nettype none

module sird_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [Width-1:0] data_o,
  output      logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("Queue fill count exceeds its depth.");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("Queue pointers differ while the queue is empty.");

endmodule

`default_nettype wire

/* rtl/sird_cfg.sv */
`default_nettype none

module sird_cfg import sird_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output      logic [APB_DATA_W-1:0] prdata,
  output      logic                  pready,
  output      cfg_t                  cfg_o
);

  logic [RADIX_W-1:0]    count_q;
  logic [APB_DATA_W-1:0] low_q, high_q;
  logic [1:0]            reg_idx;
  logic                  wr_en;
  logic [MAX_SYMBOLS-1:0][SYM_W-1:0] sym;
  logic                  ok;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel & penable & pwrite & pready;
  assign sym     = {high_q, low_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      low_q   <= '0;
      high_q  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SYMBOL_COUNT: count_q <= pwdata[RADIX_W-1:0];
        REG_SYMBOLS_LOW:  low_q   <= pwdata;
        REG_SYMBOLS_HIGH: high_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SYMBOL_COUNT: prdata = {{(APB_DATA_W - RADIX_W){1'b0}}, count_q};
      REG_SYMBOLS_LOW:  prdata = low_q;
      REG_SYMBOLS_HIGH: prdata = high_q;
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    ok = (count_q >= RADIX_W'(2)) && (count_q <= RADIX_W'(MAX_SYMBOLS));
    for (int j = 0; j < MAX_SYMBOLS; j++) begin
      if (RADIX_W'(j) < count_q) begin
        if (sym[j] == CH_MINUS || sym[j] == CH_PLUS || sym[j] < CH_LOW ||
            sym[j] >= CH_HIGH) begin
          ok = 1'b0;
        end
        for (int k = j + 1; k < MAX_SYMBOLS; k++) begin
          if (RADIX_W'(k) < count_q && sym[k] == sym[j]) begin
            ok = 1'b0;
          end
        end
      end
    end
  end

  assign cfg_o.ok    = ok;
  assign cfg_o.radix = count_q;
  assign cfg_o.sym   = sym;

endmodule

`default_nettype wire

/* rtl/sird_front.sv */
`default_nettype none

module sird_front import sird_pkg::*; (
  input  wire logic               push,
  input  wire logic [VALUE_W-1:0] value_i,
  output      logic               full,
  input  wire logic               cfg_ok_i,
  input  wire logic               q_full_i,
  output      logic               q_push_o,
  output      job_t               q_job_o
);

  logic accept;

  // Items that arrive while the alphabet is unusable are taken and dropped.
  assign full          = q_full_i;
  assign accept        = push & ~q_full_i;
  assign q_push_o      = accept & cfg_ok_i;
  assign q_job_o.neg   = value_i[VALUE_W-1];
  assign q_job_o.mag   = value_i[VALUE_W-1] ? (VALUE_W'(0) - value_i) : value_i;

endmodule

`default_nettype wire

/* rtl/sird_back.sv */
`default_nettype none

module sird_back import sird_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             q_empty_i,
  input  wire job_t             q_job_i,
  output      logic             q_pop_o,
  output      logic [SYM_W-1:0] symbol_o,
  output      logic             last_o,
  output      logic             empty,
  input  wire logic             pop
);

  localparam int unsigned AddrW = $clog2(MAX_DIGITS);

  back_state_e             st_q, st_d;
  logic [VALUE_W-1:0]      mag_q, mag_d;
  logic [DIGIT_W-1:0]      rem_q, rem_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    neg_q, neg_d;

  logic [BITS_PER_STEP-1:0] div_qb;
  logic [DIGIT_W-1:0]       div_rem;
  logic [VALUE_W-1:0]       div_quo;

  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_raddr;
  logic [DIGIT_W-1:0]  ram_rdata;

  logic                out_push, out_full;
  out_item_t           out_item, out_head;

  // Restoring division of the top bits of the dividend by the radix.
  always_comb begin
    logic [DIGIT_W:0] t;
    logic [DIGIT_W-1:0] r;
    r      = rem_q;
    div_qb = '0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      t = {r, mag_q[VALUE_W-1-i]};
      if (t >= cfg_i.radix) begin
        div_qb[BITS_PER_STEP-1-i] = 1'b1;
        r = DIGIT_W'(t - cfg_i.radix);
      end else begin
        r = t[DIGIT_W-1:0];
      end
    end
    div_rem = r;
    div_quo = {mag_q[VALUE_W-BITS_PER_STEP-1:0], div_qb};
  end

  assign ram_raddr = AddrW'(cnt_q - 1'b1);

  always_comb begin
    st_d     = st_q;
    mag_d    = mag_q;
    rem_d    = rem_q;
    step_d   = step_q;
    cnt_d    = cnt_q;
    neg_d    = neg_q;
    q_pop_o  = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    out_push = 1'b0;
    out_item = '0;
    unique case (st_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          mag_d   = q_job_i.mag;
          neg_d   = q_job_i.neg;
          cnt_d   = '0;
          rem_d   = '0;
          step_d  = '0;
          st_d    = B_DIV;
        end
      end
      B_DIV: begin
        mag_d  = div_quo;
        rem_d  = div_rem;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          ram_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          rem_d  = '0;
          if (div_quo == '0) begin
            st_d = neg_q ? B_SIGN : B_RD;
          end
        end
      end
      B_SIGN: begin
        if (!out_full) begin
          out_push        = 1'b1;
          out_item.symbol = CH_MINUS;
          out_item.last   = 1'b0;
          st_d            = B_RD;
        end
      end
      B_RD: begin
        ram_re = 1'b1;
        st_d   = B_EMIT;
      end
      B_EMIT: begin
        if (!out_full) begin
          out_push        = 1'b1;
          out_item.symbol = cfg_i.sym[ram_rdata];
          out_item.last   = (cnt_q == CNT_W'(1));
          cnt_d           = cnt_q - 1'b1;
          st_d            = (cnt_q == CNT_W'(1)) ? B_IDLE : B_RD;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= B_IDLE;
      mag_q  <= '0;
      rem_q  <= '0;
      step_q <= '0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      st_q   <= st_d;
      mag_q  <= mag_d;
      rem_q  <= rem_d;
      step_q <= step_d;
      cnt_q  <= cnt_d;
      neg_q  <= neg_d;
    end
  end

  sird_ram #(
    .Width(DIGIT_W),
    .Depth(MAX_DIGITS)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[AddrW-1:0]),
    .wdata_i(div_rem),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  sird_fifo #(
    .Width($bits(out_item_t)),
    .Depth(QUEUE_DEPTH)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_item),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (out_head),
    .empty_o(empty)
  );

  assign symbol_o = out_head.symbol;
  assign last_o   = out_head.last;

  a_stack_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_DIV && step_q == STEP_W'(DIV_STEPS - 1)) |-> (cnt_q < CNT_W'(MAX_DIGITS)))
    else $error("Digit stack written beyond its depth.");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_IDLE) |-> (cnt_q == '0))
    else $error("Back end idle with digits still stacked.");

  a_emit_has_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_RD || st_q == B_EMIT) |-> (cnt_q != '0))
    else $error("Digit read with an empty stack.");

endmodule

`default_nettype wire

/* rtl/signed_integer_to_radix_digits.sv */
// Each number leaves as D digit beats, D being the digit count (1 to 32);
// a negative number adds one beat for '-'.
// The back end takes a new number only after the last beat of the previous one; it uses
// the 8-bit-per-cycle divider, then a stack read (B_RD, then B_EMIT) per beat.
// Reset clears the registers, so the alphabet is invalid and items are dropped.
// The digit stack is not cleared; every number fills it before it is read.
`default_nettype none

module signed_integer_to_radix_digits import sird_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output      logic [APB_DATA_W-1:0] prdata,
  output      logic                  pready,
  input  wire logic                  push,
  input  wire logic signed [VALUE_W-1:0] value_i,
  output      logic                  full,
  output      logic                  empty,
  input  wire logic                  pop,
  output      logic [SYM_W-1:0]      symbol_o,
  output      logic                  last_o
);

  cfg_t cfg;
  job_t in_job, q_job;
  logic q_push, q_full, q_pop, q_empty;

  sird_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  sird_front u_front (
    .push    (push),
    .value_i ($unsigned(value_i)),
    .full    (full),
    .cfg_ok_i(cfg.ok),
    .q_full_i(q_full),
    .q_push_o(q_push),
    .q_job_o (in_job)
  );

  sird_fifo #(
    .Width($bits(job_t)),
    .Depth(QUEUE_DEPTH)
  ) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (in_job),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_job),
    .empty_o(q_empty)
  );

  sird_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .q_empty_i(q_empty),
    .q_job_i  (q_job),
    .q_pop_o  (q_pop),
    .symbol_o (symbol_o),
    .last_o   (last_o),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

`default_nettype wire
